@@ rtl/laser_scan_telegram_deframer_macros.svh @@
// Assertion macros for the telegram deframer.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef LASER_SCAN_TELEGRAM_DEFRAMER_MACROS_SVH
`define LASER_SCAN_TELEGRAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LSTD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset
`define LSTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ rtl/lstd_pkg.sv @@
`default_nettype none

package lstd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_CRC_BAD,
    ST_BAD_VERSION,
    ST_TYPE_DIFF,
    ST_IO_BLOCK,
    ST_REFLECTOR,
    ST_UNKNOWN_TYPE,
    ST_SHORT
  } frame_status_t;

  localparam logic KIND_BEAM    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Header byte offsets
  localparam logic [4:0] HDR_WC_HI   = 5'd2;
  localparam logic [4:0] HDR_WC_LO   = 5'd3;
  localparam logic [4:0] HDR_VER_LO  = 5'd6;
  localparam logic [4:0] HDR_VER_HI  = 5'd7;
  localparam logic [4:0] HDR_SCAN_B0 = 5'd10;
  localparam logic [4:0] HDR_SCAN_B1 = 5'd11;
  localparam logic [4:0] HDR_SCAN_B2 = 5'd12;
  localparam logic [4:0] HDR_SCAN_B3 = 5'd13;
  localparam logic [4:0] HDR_TEL_LO  = 5'd14;
  localparam logic [4:0] HDR_TEL_HI  = 5'd15;
  localparam logic [4:0] HDR_TYPE_A  = 5'd16;
  localparam logic [4:0] HDR_TYPE_B  = 5'd17;
  localparam logic [4:0] HDR_LAST    = 5'd19;

  localparam logic [1:0]  SYNC_ZEROS_M1 = 2'd3;
  localparam logic [15:0] VER_102       = 16'h0102;
  localparam logic [15:0] VER_103       = 16'h0103;
  localparam logic [16:0] SUB_102       = 17'd20;
  localparam logic [16:0] SUB_103       = 17'd10;
  localparam logic [16:0] MIN_PAYLOAD   = 17'd2;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_SEED_RST  = 16'hFFFF;
  localparam logic [7:0]  TYPE_MEAS     = 8'hBB;
  localparam logic [7:0]  TYPE_IO       = 8'hAA;
  localparam logic [7:0]  TYPE_REFL     = 8'hCC;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] beam_index;
    logic [12:0] range_cm;
    logic [2:0]  beam_flags;
    logic [2:0]  frame_status;
    logic [31:0] scan_count;
    logic [15:0] telegram_count;
    logic        version_103;
    logic        last;
  } lstd_result_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lstd_in_reg.sv @@
`default_nettype none

module lstd_in_reg
  import lstd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            byte_valid,
  output logic [7:0]      byte_data,
  input  wire logic       byte_take
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  // Stall only while a held byte cannot move on
  assign in_stall   = valid_r && !byte_take;
  assign accept     = in_valid && !in_stall;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (byte_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the byte on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lstd_parser.sv @@
`default_nettype none

module lstd_parser
  import lstd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  byte_data,
  output logic             byte_take,
  input  wire logic        res_ready,
  output logic             res_valid,
  output lstd_result_t     res,
  input  wire logic [15:0] crc_seed
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [16:0] len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] wc_r, wc_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [31:0] scan_r, scan_nxt;
  logic [15:0] tel_r, tel_nxt;
  logic [7:0]  type_a_r, type_a_nxt;
  logic [7:0]  type_b_r, type_b_nxt;
  logic [7:0]  low_r, low_nxt;

  logic          emit;
  logic          is_verdict;
  frame_status_t status;
  logic [15:0]   crc_upd;
  logic [16:0]   size;
  logic [16:0]   sub;
  logic [17:0]   pos_p2;
  logic [15:0]   word;

  assign crc_upd = crc16_byte(crc_r, byte_data);
  assign size    = {wc_r, 1'b0};
  assign pos_p2  = {1'b0, pos_r} + 18'd2;
  assign word    = {byte_data, low_r};

  // A byte that makes no result moves on even while the output is blocked
  assign byte_take = byte_valid && (res_ready || !emit);
  assign res_valid = byte_valid && emit;

  // Next state and result for the held byte
  always_comb begin
    phase_nxt    = phase_r;
    zero_run_nxt = zero_run_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    wc_nxt       = wc_r;
    ver_nxt      = ver_r;
    scan_nxt     = scan_r;
    tel_nxt      = tel_r;
    type_a_nxt   = type_a_r;
    type_b_nxt   = type_b_r;
    low_nxt      = low_r;
    emit         = 1'b0;
    is_verdict   = 1'b0;
    status       = ST_OK;
    sub          = SUB_102;

    case (phase_r)
      PH_HUNT: begin
        if (byte_data == 8'h00) begin
          zero_run_nxt = zero_run_r + 2'd1;
          if (zero_run_r == SYNC_ZEROS_M1) begin
            phase_nxt    = PH_HEADER;
            zero_run_nxt = 2'd0;
            pos_nxt      = 17'd0;
            crc_nxt      = crc_seed;
          end
        end else begin
          zero_run_nxt = 2'd0;
        end
      end

      PH_HEADER: begin
        crc_nxt = crc_upd;
        pos_nxt = pos_r + 17'd1;
        case (pos_r[4:0])
          HDR_WC_HI:   wc_nxt[15:8]    = byte_data;
          HDR_WC_LO:   wc_nxt[7:0]     = byte_data;
          HDR_VER_LO:  ver_nxt[7:0]    = byte_data;
          HDR_VER_HI:  ver_nxt[15:8]   = byte_data;
          HDR_SCAN_B0: scan_nxt[7:0]   = byte_data;
          HDR_SCAN_B1: scan_nxt[15:8]  = byte_data;
          HDR_SCAN_B2: scan_nxt[23:16] = byte_data;
          HDR_SCAN_B3: scan_nxt[31:24] = byte_data;
          HDR_TEL_LO:  tel_nxt[7:0]    = byte_data;
          HDR_TEL_HI:  tel_nxt[15:8]   = byte_data;
          HDR_TYPE_A:  type_a_nxt      = byte_data;
          HDR_TYPE_B:  type_b_nxt      = byte_data;
          default: ;
        endcase
        // Size the payload on the last header byte
        if (pos_r[4:0] == HDR_LAST) begin
          sub = (ver_r == VER_103) ? SUB_103 : SUB_102;
          if (ver_r != VER_102 && ver_r != VER_103) begin
            emit       = 1'b1;
            is_verdict = 1'b1;
            status     = ST_BAD_VERSION;
          end else if (size < sub + MIN_PAYLOAD) begin
            emit       = 1'b1;
            is_verdict = 1'b1;
            status     = ST_SHORT;
          end else begin
            phase_nxt = PH_PAYLOAD;
            len_nxt   = size - sub;
            pos_nxt   = 17'd0;
          end
        end
      end

      PH_PAYLOAD: begin
        pos_nxt = pos_r + 17'd1;
        if (pos_p2 < {1'b0, len_r}) begin
          crc_nxt = crc_upd;
          if (!pos_r[0]) begin
            low_nxt = byte_data;
          end else begin
            emit = 1'b1;
          end
        end else if (pos_p2 == {1'b0, len_r}) begin
          low_nxt = byte_data;
        end else begin
          // Checksum complete: pick the verdict by priority
          emit       = 1'b1;
          is_verdict = 1'b1;
          if (word != crc_r) begin
            status = ST_CRC_BAD;
          end else if (type_a_r != type_b_r) begin
            status = ST_TYPE_DIFF;
          end else if (type_a_r == TYPE_MEAS) begin
            status = ST_OK;
          end else if (type_a_r == TYPE_IO) begin
            status = ST_IO_BLOCK;
          end else if (type_a_r == TYPE_REFL) begin
            status = ST_REFLECTOR;
          end else begin
            status = ST_UNKNOWN_TYPE;
          end
        end
      end

      default: begin
        phase_nxt    = PH_HUNT;
        zero_run_nxt = 2'd0;
        pos_nxt      = 17'd0;
      end
    endcase

    // Any verdict returns to hunting
    if (is_verdict) begin
      phase_nxt    = PH_HUNT;
      zero_run_nxt = 2'd0;
      pos_nxt      = 17'd0;
    end
  end

  // Assemble the result item
  always_comb begin
    res.item_kind      = is_verdict ? KIND_VERDICT : KIND_BEAM;
    res.beam_index     = is_verdict ? 16'd0 : pos_r[16:1];
    res.range_cm       = is_verdict ? 13'd0 : word[12:0];
    res.beam_flags     = is_verdict ? 3'd0 : word[15:13];
    res.frame_status   = is_verdict ? status : ST_OK;
    res.scan_count     = scan_r;
    res.telegram_count = tel_r;
    res.version_103    = (ver_r == VER_103);
    res.last           = is_verdict;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      zero_run_r <= 2'd0;
      pos_r      <= 17'd0;
      len_r      <= 17'd0;
      crc_r      <= CRC_SEED_RST;
      wc_r       <= 16'd0;
      ver_r      <= 16'd0;
      scan_r     <= 32'd0;
      tel_r      <= 16'd0;
      type_a_r   <= 8'd0;
      type_b_r   <= 8'd0;
      low_r      <= 8'd0;
    end else if (byte_take) begin
      phase_r    <= phase_nxt;
      zero_run_r <= zero_run_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      wc_r       <= wc_nxt;
      ver_r      <= ver_nxt;
      scan_r     <= scan_nxt;
      tel_r      <= tel_nxt;
      type_a_r   <= type_a_nxt;
      type_b_r   <= type_b_nxt;
      low_r      <= low_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lstd_out_reg.sv @@
`default_nettype none

module lstd_out_reg
  import lstd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire lstd_result_t  res,
  input  wire logic          res_take,
  output logic               res_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lstd_result_t       out_res
);

  logic         valid_r, valid_nxt;
  lstd_result_t res_r;
  logic         load;

  // Room when empty or when the held result leaves this cycle
  assign res_ready = !valid_r || !out_stall;
  assign load      = res_valid && res_take;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/laser_scan_telegram_deframer.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_data_byte
// out_      output     out_valid / out_stall  beam or verdict fields
// cfg_      input      cfg_valid / cfg_ready  cfg_crc_seed
//
// One byte per cycle while in_stall is low: a byte sits in the input register,
// the parser state and CRC advance, and any result lands in the output register.
// A result is offered from the output register, after its byte has left the input register.
// Reset (rst_n low, synchronous) returns to zero hunting with seed 0xFFFF.
// While the output is stalled an empty output register still takes one result;
// bytes that make no result keep flowing until a result-making byte meets a full output.
`default_nettype none

`include "laser_scan_telegram_deframer_macros.svh"

module laser_scan_telegram_deframer
  import lstd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_item_kind,
  output logic [15:0]      out_beam_index,
  output logic [12:0]      out_range_cm,
  output logic [2:0]       out_beam_flags,
  output logic [2:0]       out_frame_status,
  output logic [31:0]      out_scan_count,
  output logic [15:0]      out_telegram_count,
  output logic             out_version_103,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_crc_seed
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         byte_take;
  logic         res_valid;
  logic         res_ready;
  lstd_result_t res;
  lstd_result_t out_res;
  logic [15:0]  crc_seed_r;

  // Seed register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r <= CRC_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      crc_seed_r <= cfg_crc_seed;
    end
  end

  lstd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data),
    .byte_take    (byte_take)
  );

  lstd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .crc_seed   (crc_seed_r)
  );

  lstd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (byte_take),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_item_kind      = out_res.item_kind;
  assign out_beam_index     = out_res.beam_index;
  assign out_range_cm       = out_res.range_cm;
  assign out_beam_flags     = out_res.beam_flags;
  assign out_frame_status   = out_res.frame_status;
  assign out_scan_count     = out_res.scan_count;
  assign out_telegram_count = out_res.telegram_count;
  assign out_version_103    = out_res.version_103;
  assign out_last           = out_res.last;

  // Input only stalls behind a full, stalled output
  `LSTD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // Verdicts and only verdicts close a telegram
  `LSTD_ASSERT_NOW(a_last_kind, out_valid, out_last == out_item_kind)
  // A beam never carries a status
  `LSTD_ASSERT_NOW(a_beam_clean, out_valid && !out_item_kind, out_frame_status == ST_OK)
  // A taken byte that yields a result shows up at the output next cycle
  `LSTD_ASSERT_NEXT(a_result_lands, res_valid && byte_take, out_valid)

endmodule

`default_nettype wire

@@ sim/telegram_deframer_monitor.sv @@
`default_nettype none

module telegram_deframer_monitor
  import lstd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_item_kind,
  input  wire logic [15:0] out_beam_index,
  input  wire logic [12:0] out_range_cm,
  input  wire logic [2:0]  out_beam_flags,
  input  wire logic [2:0]  out_frame_status,
  input  wire logic [31:0] out_scan_count,
  input  wire logic [15:0] out_telegram_count,
  input  wire logic        out_version_103,
  input  wire logic        out_last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_crc_seed,
  output int               fails,
  output int               expected_left,
  output int               beams_seen,
  output int               verdicts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SYNC_ZEROS = 3'd4;

  // Shadow copy of the parser state
  logic [15:0]  seed_reg;
  phase_t       phase;
  logic [2:0]   zero_run;
  logic [16:0]  byte_pos;
  logic [16:0]  payload_len;
  logic [15:0]  crc_acc;
  logic [15:0]  word_count;
  logic [15:0]  version_word;
  logic [31:0]  scan_reg;
  logic [15:0]  telegram_reg;
  logic [7:0]   type_a;
  logic [7:0]   type_b;
  logic [7:0]   low_byte;

  // Beams and verdicts still owed by the block, oldest first
  lstd_result_t awaited_results[$];

  // Bit-serial form of the CRC-16 update, MSB first
  function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic lstd_result_t make_item(logic kind, logic [15:0] idx,
                                             logic [15:0] word, frame_status_t st,
                                             logic ends);
    lstd_result_t r;
    r.item_kind      = kind;
    r.beam_index     = idx;
    r.range_cm       = word[12:0];
    r.beam_flags     = word[15:13];
    r.frame_status   = st;
    r.scan_count     = scan_reg;
    r.telegram_count = telegram_reg;
    r.version_103    = (version_word == VER_103);
    r.last           = ends;
    return r;
  endfunction

  task automatic clear_state();
    seed_reg     = CRC_SEED_RST;
    phase        = PH_HUNT;
    zero_run     = '0;
    byte_pos     = '0;
    payload_len  = '0;
    crc_acc      = CRC_SEED_RST;
    word_count   = '0;
    version_word = '0;
    scan_reg     = '0;
    telegram_reg = '0;
    type_a       = '0;
    type_b       = '0;
    low_byte     = '0;
    awaited_results.delete();
  endtask

  // Queue a verdict and go back to hunting
  task automatic close_telegram(frame_status_t st);
    awaited_results.push_back(make_item(KIND_VERDICT, '0, '0, st, 1'b1));
    phase    = PH_HUNT;
    zero_run = '0;
    byte_pos = '0;
  endtask

  // Advance the parser by one byte and queue whatever it emits
  task automatic parse_byte(logic [7:0] b);
    logic [16:0] p;
    logic [16:0] size;
    logic [16:0] sub;
    logic [15:0] rx;
    p = byte_pos;
    case (phase)
      PH_HUNT: begin
        if (b == 8'h00) begin
          zero_run = zero_run + 3'd1;
          if (zero_run >= SYNC_ZEROS) begin
            phase    = PH_HEADER;
            zero_run = '0;
            byte_pos = '0;
            crc_acc  = seed_reg;
          end
        end else begin
          zero_run = '0;
        end
      end
      PH_HEADER: begin
        crc_acc = crc_fold(crc_acc, b);
        case (p[4:0])
          HDR_WC_HI:   word_count[15:8]   = b;
          HDR_WC_LO:   word_count[7:0]    = b;
          HDR_VER_LO:  version_word[7:0]  = b;
          HDR_VER_HI:  version_word[15:8] = b;
          HDR_SCAN_B0: scan_reg[7:0]      = b;
          HDR_SCAN_B1: scan_reg[15:8]     = b;
          HDR_SCAN_B2: scan_reg[23:16]    = b;
          HDR_SCAN_B3: scan_reg[31:24]    = b;
          HDR_TEL_LO:  telegram_reg[7:0]  = b;
          HDR_TEL_HI:  telegram_reg[15:8] = b;
          HDR_TYPE_A:  type_a             = b;
          HDR_TYPE_B:  type_b             = b;
          default: ;
        endcase
        byte_pos = p + 17'd1;
        if (p == 17'(HDR_LAST)) begin
          // Length at full 17 bits, no wrap of the doubled word count
          size = {word_count, 1'b0};
          if (version_word == VER_102) begin
            sub = SUB_102;
          end else begin
            sub = SUB_103;
          end
          if (version_word != VER_102 && version_word != VER_103) begin
            close_telegram(ST_BAD_VERSION);
          end else if (size < sub + MIN_PAYLOAD) begin
            close_telegram(ST_SHORT);
          end else begin
            payload_len = size - sub;
            phase       = PH_PAYLOAD;
            byte_pos    = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        byte_pos = p + 17'd1;
        if (payload_len < MIN_PAYLOAD) begin
          close_telegram(ST_SHORT);
        end else if (p + 17'd2 < payload_len) begin
          crc_acc = crc_fold(crc_acc, b);
          if (!p[0]) begin
            low_byte = b;
          end else begin
            awaited_results.push_back(make_item(KIND_BEAM, p[16:1], {b, low_byte},
                                                ST_OK, 1'b0));
          end
        end else if (p + 17'd2 == payload_len) begin
          low_byte = b;
        end else begin
          // Checksum complete: crc first, then type agreement, then type value
          rx = {b, low_byte};
          if (rx != crc_acc) begin
            close_telegram(ST_CRC_BAD);
          end else if (type_a != type_b) begin
            close_telegram(ST_TYPE_DIFF);
          end else if (type_a == TYPE_MEAS) begin
            close_telegram(ST_OK);
          end else if (type_a == TYPE_IO) begin
            close_telegram(ST_IO_BLOCK);
          end else if (type_a == TYPE_REFL) begin
            close_telegram(ST_REFLECTOR);
          end else begin
            close_telegram(ST_UNKNOWN_TYPE);
          end
        end
      end
      default: begin
        phase    = PH_HUNT;
        zero_run = '0;
        byte_pos = '0;
      end
    endcase
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result();
    lstd_result_t got;
    lstd_result_t want;
    got.item_kind      = out_item_kind;
    got.beam_index     = out_beam_index;
    got.range_cm       = out_range_cm;
    got.beam_flags     = out_beam_flags;
    got.frame_status   = out_frame_status;
    got.scan_count     = out_scan_count;
    got.telegram_count = out_telegram_count;
    got.version_103    = out_version_103;
    got.last           = out_last;
    if (awaited_results.size() == 0) begin
      $error("result with nothing awaited: kind %0d status %0d", got.item_kind,
             got.frame_status);
      fails++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
      compare_field("beam_index", 64'(want.beam_index), 64'(got.beam_index));
      compare_field("range_cm", 64'(want.range_cm), 64'(got.range_cm));
      compare_field("beam_flags", 64'(want.beam_flags), 64'(got.beam_flags));
      compare_field("frame_status", 64'(want.frame_status), 64'(got.frame_status));
      compare_field("scan_count", 64'(want.scan_count), 64'(got.scan_count));
      compare_field("telegram_count", 64'(want.telegram_count),
                    64'(got.telegram_count));
      compare_field("version_103", 64'(want.version_103), 64'(got.version_103));
      compare_field("last", 64'(want.last), 64'(got.last));
    end
    if (got.item_kind == KIND_BEAM) begin
      beams_seen++;
    end else begin
      verdicts_seen++;
    end
  endtask

  // Inputs move only at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_state();
      fails         = 0;
      beams_seen    = 0;
      verdicts_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_crc_seed;
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_data_byte);
      end
    end
    expected_left = awaited_results.size();
  end

endmodule

`default_nettype wire

@@ sim/tb_laser_scan_telegram_deframer.sv @@
`default_nettype none

module tb_laser_scan_telegram_deframer
  import lstd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_BYTES  = 240;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_item_kind;
  logic [15:0] out_beam_index;
  logic [12:0] out_range_cm;
  logic [2:0]  out_beam_flags;
  logic [2:0]  out_frame_status;
  logic [31:0] out_scan_count;
  logic [15:0] out_telegram_count;
  logic        out_version_103;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_crc_seed;

  int          fails;
  int          expected_left;
  int          beams_seen;
  int          verdicts_seen;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          noise_sent = 0;
  int          seeds_used = 1;
  logic [15:0] seed_now = CRC_SEED_RST;
  bit          quiet = 1'b0;
  bit          gappy = 1'b1;

  laser_scan_telegram_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_beam_index     (out_beam_index),
    .out_range_cm       (out_range_cm),
    .out_beam_flags     (out_beam_flags),
    .out_frame_status   (out_frame_status),
    .out_scan_count     (out_scan_count),
    .out_telegram_count (out_telegram_count),
    .out_version_103    (out_version_103),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_crc_seed       (cfg_crc_seed)
  );

  telegram_deframer_monitor monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_beam_index     (out_beam_index),
    .out_range_cm       (out_range_cm),
    .out_beam_flags     (out_beam_flags),
    .out_frame_status   (out_frame_status),
    .out_scan_count     (out_scan_count),
    .out_telegram_count (out_telegram_count),
    .out_version_103    (out_version_103),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_crc_seed       (cfg_crc_seed),
    .fails              (fails),
    .expected_left      (expected_left),
    .beams_seen         (beams_seen),
    .verdicts_seen      (verdicts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("laser_scan_telegram_deframer: mismatch");
      $finish;
    end
  end

  // Result side back-pressure: calm stretches, then stall bursts
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(60, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte, optionally after an idle burst, and hold it until the transfer
  task automatic push_byte(input logic [7:0] b);
    logic held;
    if ($urandom_range(0, 99) == 0) begin
      gappy = !gappy;
    end
    if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    bytes_sent++;
  endtask

  // Drop valid and let every owed result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [15:0] v);
    logic rdy;
    cfg_valid    <= 1'b1;
    cfg_crc_seed <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    seed_now = v;
    seeds_used++;
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_version();
    return ($urandom_range(0, 1) != 0) ? VER_103 : VER_102;
  endfunction

  // Word count that yields the given number of beams
  function automatic logic [15:0] wc_for(logic [15:0] ver, int nbeams);
    int sub;
    sub = (ver == VER_102) ? int'(SUB_102) : int'(SUB_103);
    return 16'(nbeams + 1 + sub / 2);
  endfunction

  // Sync zeros, header, and, when the header allows one, payload and checksum.
  // A cut telegram sends only the start of a long payload.
  task automatic send_telegram(input logic [15:0] wc, input logic [15:0] ver,
                               input logic [31:0] scan, input logic [15:0] tel,
                               input logic [7:0] type_a, input logic [7:0] type_b,
                               input bit spoil_crc, input bit cut);
    logic [7:0]  hdr[20];
    logic [15:0] crc;
    logic [7:0]  b;
    int          len;
    int          body;
    for (int i = 0; i < 20; i++) begin
      hdr[i] = 8'($urandom_range(0, 255));
    end
    hdr[HDR_WC_HI]   = wc[15:8];
    hdr[HDR_WC_LO]   = wc[7:0];
    hdr[HDR_VER_LO]  = ver[7:0];
    hdr[HDR_VER_HI]  = ver[15:8];
    hdr[HDR_SCAN_B0] = scan[7:0];
    hdr[HDR_SCAN_B1] = scan[15:8];
    hdr[HDR_SCAN_B2] = scan[23:16];
    hdr[HDR_SCAN_B3] = scan[31:24];
    hdr[HDR_TEL_LO]  = tel[7:0];
    hdr[HDR_TEL_HI]  = tel[15:8];
    hdr[HDR_TYPE_A]  = type_a;
    hdr[HDR_TYPE_B]  = type_b;
    repeat (4) push_byte(8'h00);
    crc = seed_now;
    for (int i = 0; i < 20; i++) begin
      crc = crc16_byte(crc, hdr[i]);
      push_byte(hdr[i]);
    end
    if (ver != VER_102 && ver != VER_103) begin
      return;
    end
    len = 2 * int'(wc) - ((ver == VER_102) ? int'(SUB_102) : int'(SUB_103));
    if (len < int'(MIN_PAYLOAD)) begin
      return;
    end
    body = cut ? 40 : len - 2;
    for (int i = 0; i < body; i++) begin
      b = payload_byte();
      crc = crc16_byte(crc, b);
      push_byte(b);
    end
    if (cut) begin
      return;
    end
    if (spoil_crc) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endtask

  // Line noise, zero-heavy, closed by a nonzero byte so sync stays aligned
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    repeat (n - 1) begin
      push_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    end
    push_byte(8'($urandom_range(1, 255)));
    noise_sent += n;
  endtask

  task automatic send_random_item();
    logic [15:0] ver;
    logic [7:0]  ta;
    logic [7:0]  tb;
    int          nbeams;
    ver = pick_version();
    case ($urandom_range(0, 19))
      0, 1: send_noise();
      2, 3: begin
        // Unsupported version, any word count
        ver = 16'($urandom);
        if (ver == VER_102 || ver == VER_103) begin
          ver = ~ver;
        end
        send_telegram(16'($urandom), ver, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                      1'b0, 1'b0);
      end
      4: begin
        send_telegram(16'($urandom_range(0, (ver == VER_102) ? 10 : 5)), ver, $urandom,
                      16'($urandom), TYPE_MEAS, TYPE_MEAS, 1'b0, 1'b0);
      end
      default: begin
        nbeams = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
        case ($urandom_range(0, 9))
          0: ta = TYPE_IO;
          1: ta = TYPE_REFL;
          2: ta = 8'($urandom_range(0, 255));
          default: ta = TYPE_MEAS;
        endcase
        tb = ta;
        if ($urandom_range(0, 9) == 0) begin
          tb = ta ^ 8'($urandom_range(1, 255));
        end
        send_telegram(wc_for(ver, nbeams), ver, $urandom, 16'($urandom), ta, tb,
                      $urandom_range(0, 9) == 0, 1'b0);
      end
    endcase
  endtask

  initial begin
    logic [15:0] seed_plan[5];
    int          start;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    cfg_valid    <= 1'b0;
    cfg_crc_seed <= 16'h0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every verdict, field extremes, length edges, sync recovery
    send_telegram(wc_for(VER_102, 4), VER_102, 32'h0, 16'h0, TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(wc_for(VER_103, 3), VER_103, 32'hFFFF_FFFF, 16'hFFFF, TYPE_MEAS,
                  TYPE_MEAS, 1'b0, 1'b0);
    send_telegram(wc_for(VER_102, 1), VER_102, $urandom, 16'($urandom), TYPE_IO, TYPE_IO,
                  1'b0, 1'b0);
    send_telegram(wc_for(VER_103, 1), VER_103, $urandom, 16'($urandom), TYPE_REFL,
                  TYPE_REFL, 1'b0, 1'b0);
    send_telegram(wc_for(VER_102, 2), VER_102, $urandom, 16'($urandom), 8'h00, 8'h00,
                  1'b0, 1'b0);
    send_telegram(wc_for(VER_103, 2), VER_103, $urandom, 16'($urandom), 8'hFF, 8'hFF,
                  1'b0, 1'b0);
    send_telegram(wc_for(VER_102, 2), VER_102, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_REFL, 1'b0, 1'b0);
    send_telegram(wc_for(VER_102, 3), VER_102, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_MEAS, 1'b1, 1'b0);
    // CRC error outranks a type disagreement
    send_telegram(wc_for(VER_103, 1), VER_103, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_IO, 1'b1, 1'b0);
    send_telegram(16'h0010, 16'h0000, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'hFFFF, 16'hFFFF, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'h0010, 16'h0201, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'h0000, VER_102, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'h000A, VER_102, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'h0005, VER_103, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    send_telegram(16'h0000, VER_103, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b0);
    // Smallest valid payloads: checksum only, no beams
    send_telegram(wc_for(VER_102, 0), VER_102, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_MEAS, 1'b0, 1'b0);
    send_telegram(wc_for(VER_103, 0), VER_103, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_MEAS, 1'b0, 1'b0);
    // Broken zero run must restart the count
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h80);
    send_telegram(wc_for(VER_102, 2), VER_102, $urandom, 16'($urandom), TYPE_MEAS,
                  TYPE_MEAS, 1'b0, 1'b0);

    // Random telegrams under a sequence of seeds, extremes included
    seed_plan[0] = 16'h0000;
    seed_plan[1] = 16'($urandom);
    seed_plan[2] = 16'hFFFF;
    seed_plan[3] = 16'($urandom);
    seed_plan[4] = 16'h1D0F;
    for (int k = 0; k < 5; k++) begin
      settle();
      write_seed(seed_plan[k]);
      quiet = (k == 4);
      start = bytes_sent - noise_sent;
      while (bytes_sent - noise_sent - start < PHASE_BYTES) begin
        send_random_item();
      end
    end

    // Largest word count: 17-bit length, left open after its first beams
    send_telegram(16'hFFFF, VER_102, $urandom, 16'($urandom), TYPE_MEAS, TYPE_MEAS,
                  1'b0, 1'b1);
    settle();

    $display("Streamed %0d bytes (%0d of them noise) under %0d CRC seed settings.",
             bytes_sent, noise_sent, seeds_used);
    $display("Compared %0d beams and %0d telegram verdicts, %0d field errors.",
             beams_seen, verdicts_seen, fails);
    if (fails == 0) begin
      $display("laser_scan_telegram_deframer: match");
    end else begin
      $display("laser_scan_telegram_deframer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/lstd_pkg.sv
rtl/lstd_in_reg.sv
rtl/lstd_parser.sv
rtl/lstd_out_reg.sv
rtl/laser_scan_telegram_deframer.sv
sim/telegram_deframer_monitor.sv
sim/tb_laser_scan_telegram_deframer.sv
